FILE: src/mlv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_pkg
// Shared types and constants for the median of loaded values block.
// ----------------------------------------------------------------------------
package mlv_pkg;

	localparam int SAMPLE_W = 8;
	localparam int SIZE_W   = 5;
	localparam int OUT_W    = 16;

	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef enum logic {
		ST_LOAD,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic    ins;
		logic    shift;
		sample_t v;
	} cell_ctrl_t;

endpackage
`default_nettype wire

FILE: src/median_of_loaded_values.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_of_loaded_values
// Sorted insertion chain that reports the median of each set on its last value.
//
// Channel  Dir  Payload
// s_*      in   tdata[7:0] sample, tlast final_item
// m_*      out  tdata[7:0] median_whole, [8] median_half, [13:9] set_size,
//               [14] overflowed, [15] zero
//
// A value enters the chain each cycle in the load state; the cells put it in
// order as it is registered. After a final value the chain shifts toward its
// head until the middle value or pair leads it; then the result is registered.
// Input is held off while the chain drains or a result cannot be loaded.
// Reset clears the count, step count, drop flag, state and output valid.
// ----------------------------------------------------------------------------
module median_of_loaded_values #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [7:0]                 s_tdata,   // sample
	input  wire logic                       s_tlast,   // final_item
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [mlv_pkg::OUT_W-1:0]       m_tdata    // whole, half, size, overflowed
);
	import mlv_pkg::*;

	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

	state_t        state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] steps_q, steps_d;
	logic          drop_q, drop_d;
	logic          out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic          load_out;
	logic [OUT_W-1:0] out_data_d;

	cell_ctrl_t    ctl;
	logic          accept, full;
	logic [CW-1:0] new_count;
	logic [MAX_ENTRIES-1:0] gt;
	sample_t       vals [MAX_ENTRIES];
	logic [SAMPLE_W:0] sum;
	logic [CW+SIZE_W-1:0] size_wide;

	assign full      = (count_q == FULL);
	assign accept    = s_tvalid && s_tready;
	assign new_count = full ? count_q : count_q + CW'(1);
	assign s_tready  = (state_q == ST_LOAD);
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign sum       = {1'b0, vals[0]} + {1'b0, vals[1]};
	assign size_wide = {{SIZE_W{1'b0}}, count_q};

	genvar i;
	generate
		for (i = 0; i < MAX_ENTRIES; i++) begin : g_cell
			logic    valid_c, prev_gt_c;
			sample_t prev_val_c, next_val_c;
			assign valid_c = (count_q > CW'(i));
			if (i == 0) begin : g_head
				assign prev_gt_c  = 1'b0;
				assign prev_val_c = vals[0];
			end else begin : g_body
				assign prev_gt_c  = gt[i-1];
				assign prev_val_c = vals[i-1];
			end
			if (i == MAX_ENTRIES - 1) begin : g_tail
				assign next_val_c = vals[i];
			end else begin : g_mid
				assign next_val_c = vals[i+1];
			end
			mlv_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.valid_i    (valid_c),
				.prev_gt_i  (prev_gt_c),
				.prev_val_i (prev_val_c),
				.next_val_i (next_val_c),
				.gt_o       (gt[i]),
				.val_o      (vals[i])
			);
		end
	endgenerate

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		steps_d    = steps_q;
		drop_d     = drop_q;
		load_out   = 1'b0;
		out_data_d = out_data_q;
		ctl.v      = s_tdata;
		ctl.ins    = 1'b0;
		ctl.shift  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (accept) begin
					ctl.ins = !full;
					count_d = new_count;
					if (full) begin
						drop_d = 1'b1;
					end
					if (s_tlast) begin
						steps_d = (new_count - CW'(1)) >> 1;
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (steps_q != '0) begin
					ctl.shift = 1'b1;
					steps_d   = steps_q - CW'(1);
				end else if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					out_data_d[OUT_W-1] = 1'b0;
					out_data_d[14]      = drop_q;
					out_data_d[13:9]    = size_wide[SIZE_W-1:0];
					if (count_q[0]) begin
						out_data_d[8]   = 1'b0;
						out_data_d[7:0] = vals[0];
					end else begin
						out_data_d[8]   = sum[0];
						out_data_d[7:0] = sum[SAMPLE_W:1];
					end
					count_d = '0;
					drop_d  = 1'b0;
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			count_q     <= '0;
			steps_q     <= '0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			steps_q <= steps_d;
			drop_q  <= drop_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= out_data_d;
		end
	end

endmodule
`default_nettype wire

FILE: src/mlv_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_cell
// One insertion cell: holds a value, inserts in order, shifts toward the head.
// ----------------------------------------------------------------------------
module mlv_cell (
	input  wire logic               clk,
	input  wire mlv_pkg::cell_ctrl_t ctl,
	input  wire logic               valid_i,
	input  wire logic               prev_gt_i,
	input  wire mlv_pkg::sample_t   prev_val_i,
	input  wire mlv_pkg::sample_t   next_val_i,
	output logic                    gt_o,
	output mlv_pkg::sample_t        val_o
);
	import mlv_pkg::*;

	sample_t val_q;

	assign gt_o  = !valid_i || (val_q > ctl.v);
	assign val_o = val_q;

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (gt_o) begin
				val_q <= prev_gt_i ? prev_val_i : ctl.v;
			end
		end else if (ctl.shift) begin
			val_q <= next_val_i;
		end
	end

endmodule
`default_nettype wire

FILE: src/mlv_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlv_checker
// Port-level checks for the median block, bound to the top level.
// ----------------------------------------------------------------------------
module mlv_checker #(
	parameter int MAX_ENTRIES = 16
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        s_tlast,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata
);
	localparam logic [4:0] MAX_SIZE = 5'(MAX_ENTRIES);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("request taken right after a final value");

	a_odd_no_half: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[9] |-> !m_tdata[8])
		else $error("half bit set on an odd-sized set");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[14] |-> m_tdata[13:9] == MAX_SIZE && !m_tdata[15])
		else $error("overflow reported on a set that is not full");

endmodule

bind median_of_loaded_values mlv_checker #(.MAX_ENTRIES(MAX_ENTRIES)) u_mlv_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for median_of_loaded_values: sets of samples go in over
// the input stream, each median is predicted by an in-bench sorted store and
// compared field by field against the output stream under varied stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import mlv_pkg::*;

	localparam int MAX_ENTRIES  = 16;
	localparam int RANDOM_ITEMS = 1750;
	localparam int DRAIN_CYCLES = MAX_ENTRIES + 16;

	typedef struct packed {
		logic              overflowed;
		logic [SIZE_W-1:0] set_size;
		logic              half;
		sample_t           whole;
	} median_t;

	typedef struct packed {
		sample_t sample;
		logic    last;
		logic    typed;
		median_t result;
	} request_row_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	sample_t          s_tdata;
	logic             s_tlast;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	sample_t      held_values[$];
	logic         set_dropped;
	median_t      medians_due[$];
	request_row_t rows[$];
	int           mismatch_count;
	int           phase;

	median_of_loaded_values #(
		.MAX_ENTRIES(MAX_ENTRIES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb_top failed");
		$finish;
	end

	function automatic median_t median_of(sample_t whole, logic half, int count, logic ovf);
		median_t r;
		r.whole      = whole;
		r.half       = half;
		r.set_size   = count[SIZE_W-1:0];
		r.overflowed = ovf;
		return r;
	endfunction

	// insert into the sorted set; on the final sample produce its median
	function automatic bit load_sample(sample_t v, logic last, output median_t res);
		int         pos;
		int         n;
		logic [8:0] sum;
		res = '0;
		if (held_values.size() >= MAX_ENTRIES) begin
			set_dropped = 1'b1;
		end else begin
			pos = 0;
			while (pos < held_values.size() && held_values[pos] <= v)
				pos++;
			held_values.insert(pos, v);
		end
		if (!last)
			return 1'b0;
		n = held_values.size();
		if (n % 2) begin
			res.whole = held_values[n / 2];
		end else begin
			sum       = {1'b0, held_values[n / 2 - 1]} + {1'b0, held_values[n / 2]};
			res.whole = sum[8:1];
			res.half  = sum[0];
		end
		res.set_size   = n[SIZE_W-1:0];
		res.overflowed = set_dropped;
		held_values.delete();
		set_dropped = 1'b0;
		return 1'b1;
	endfunction

	task automatic send_request(sample_t v, logic last, logic typed, median_t typed_res);
		median_t res;
		int      gap_pct;
		gap_pct = (phase == 0) ? 6 : (phase == 1) ? 77 : 0;
		while ($urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
		if (load_sample(v, last, res))
			medians_due.push_back(typed ? typed_res : res);
	endtask

	task automatic report(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= ((phase == 0) ? 77 : (phase == 1) ? 6 : 0));
	end

	always @(negedge clk) begin : result_check
		median_t got;
		median_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = median_t'(m_tdata[14:0]);
			if (medians_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = medians_due.pop_front();
				if (got.whole != want.whole)
					report("median_whole", int'(want.whole), int'(got.whole));
				if (got.half != want.half)
					report("median_half", int'(want.half), int'(got.half));
				if (got.set_size != want.set_size)
					report("set_size", int'(want.set_size), int'(got.set_size));
				if (got.overflowed != want.overflowed)
					report("overflowed", int'(want.overflowed), int'(got.overflowed));
			end
		end
	end

	initial begin : stimulus
		median_t none;
		sample_t v;
		int      sent;
		int      len;
		int      mode;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tlast        = 1'b0;
		m_tready       = 1'b0;
		arst_n         = 1'b0;
		phase          = 0;
		mismatch_count = 0;
		set_dropped    = 1'b0;
		none           = '0;

		rows.push_back({8'd0,   1'b1, 1'b1, median_of(8'd0,   1'b0, 1, 1'b0)});
		rows.push_back({8'd255, 1'b1, 1'b1, median_of(8'd255, 1'b0, 1, 1'b0)});
		rows.push_back({8'd255, 1'b0, 1'b0, none});
		rows.push_back({8'd0,   1'b1, 1'b1, median_of(8'd127, 1'b1, 2, 1'b0)});
		rows.push_back({8'd255, 1'b0, 1'b0, none});
		rows.push_back({8'd255, 1'b1, 1'b1, median_of(8'd255, 1'b0, 2, 1'b0)});
		rows.push_back({8'd9,   1'b0, 1'b0, none});
		rows.push_back({8'd200, 1'b0, 1'b0, none});
		rows.push_back({8'd1,   1'b1, 1'b0, none});
		for (int i = 0; i < MAX_ENTRIES; i++)
			rows.push_back({8'(255 - 17 * i), 1'b0, 1'b0, none});
		// full store drops the final sample: median of 0, 17, ..., 255
		rows.push_back({8'd77, 1'b1, 1'b1, median_of(8'd127, 1'b1, MAX_ENTRIES, 1'b1)});

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_request(rows[i].sample, rows[i].last, rows[i].typed, rows[i].result);

		for (phase = 0; phase < 3; phase++) begin
			// hold off until the block has delivered everything
			s_tvalid <= 1'b0;
			while (medians_due.size() != 0)
				@(posedge clk);
			sent = 0;
			while (sent < RANDOM_ITEMS / 3) begin
				len  = ($urandom_range(0, 9) == 0) ?
					$urandom_range(MAX_ENTRIES + 1, MAX_ENTRIES + 6) :
					$urandom_range(1, MAX_ENTRIES);
				mode = $urandom_range(0, 7);
				for (int k = 0; k < len; k++) begin
					case (mode)
						0:       v = 8'($urandom_range(0, 3));
						1:       v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
						2:       v = 8'($urandom_range(250, 255));
						default: v = 8'($urandom);
					endcase
					send_request(v, k == len - 1, 1'b0, none);
				end
				sent += len;
			end
		end

		s_tvalid <= 1'b0;
		while (medians_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
